/* design/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at each rising edge, held off while reset is asserted
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Check a property at each rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

/* design/scpr_pkg.sv */
package scpr_pkg;

  // Field widths
  localparam int unsigned TimeW = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned CircW = 12;
  localparam int unsigned CadW = 16;
  localparam int unsigned SpdW = 24;

  // Multiplier and divider sizing
  localparam int unsigned ProdW = CountW + CircW;     // circumference * wheel revs
  localparam int unsigned NineW = ProdW + 4;          // 9 * product
  localparam int unsigned CadNumW = CountW + 16;      // 61440 * crank revs
  localparam int unsigned SpdRemW = NineW - 12;       // speed numerator >> 24
  localparam int unsigned StepW = 5;                  // divider step counter

  // Register file
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [0:0] RegCirc = 1'b0;
  localparam logic [CircW-1:0] CircReset = 12'd2000;

  // Reset values of the previous page
  localparam logic [TimeW-1:0] PrevTimeReset = '0;
  localparam logic [CountW-1:0] PrevCountReset = 16'd1;

  // Saturation limits
  localparam logic [CadW-1:0] CadMax = '1;
  localparam logic [SpdW-1:0] SpdMax = '1;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_HOLD = 5'b10000
  } state_t;

endpackage

/* design/speed_cadence_page_rate.sv */
// Speed and cadence page rate.
// Input channel (in_valid / in_ready): one beat is one received sensor page with
// crank event time, crank revolutions, wheel event time and wheel revolutions.
// Result channel (out_valid / out_ready): one beat per page with rates_valid,
// crank_rpm, speed_tenths and overflow_or_zero_time.
// A page whose crank or wheel revolution count did not move gives an all-zero
// result through the hold state and the output register, and the stored page is
// kept; the next page is taken only once that result is in the output register.
// Any other page runs a bit-serial multiplier (one circumference bit per cycle)
// and two restoring dividers side by side (one quotient bit per cycle), then
// passes the hold state into the output register; no new page is taken until
// its result is there. A finished result sits in the output register; the block
// takes the next page while it waits, and stalls only when a second result is
// done before the first has been taken. Wheel circumference is written over the
// APB port at address 0; the user must write it only while the block is idle,
// as the block itself does not enforce this.
// Reset (rst_n low, synchronous) clears the stored page to times 0 and counts 1,
// sets circumference to 2000 and empties the output register.
module speed_cadence_page_rate
  import scpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Page input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TimeW-1:0]  in_cadence_event_time,
  input  logic [CountW-1:0] in_cadence_revolutions,
  input  logic [TimeW-1:0]  in_speed_event_time,
  input  logic [CountW-1:0] in_speed_revolutions,
  // Result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_rates_valid,
  output logic [CadW-1:0]   out_crank_rpm,
  output logic [SpdW-1:0]   out_speed_tenths,
  output logic              out_overflow_or_zero_time,
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  `include "assert_macros.svh"

  // Control state
  state_t              state_r, state_nxt;
  logic [StepW-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CircW-1:0]    circ_r, circ_nxt;
  logic [TimeW-1:0]    prev_ct_r, prev_ct_nxt;
  logic [CountW-1:0]   prev_cn_r, prev_cn_nxt;
  logic [TimeW-1:0]    prev_st_r, prev_st_nxt;
  logic [CountW-1:0]   prev_sn_r, prev_sn_nxt;

  // Datapath
  logic                vld_r, vld_nxt;
  logic [TimeW-1:0]    dct_r, dct_nxt;
  logic [TimeW-1:0]    dst_r, dst_nxt;
  logic [CountW-1:0]   dsn_r, dsn_nxt;
  logic [CadNumW-1:0]  ncad_r, ncad_nxt;
  logic [CircW-1:0]    mc_r, mc_nxt;
  logic [ProdW-1:0]    acc_r, acc_nxt;
  logic [CadW-1:0]     rem_c_r, rem_c_nxt;
  logic [CadW-1:0]     qn_c_r, qn_c_nxt;
  logic [SpdRemW-1:0]  rem_s_r, rem_s_nxt;
  logic [SpdW-1:0]     qn_s_r, qn_s_nxt;
  logic                ovf_c_r, ovf_c_nxt;
  logic                ovf_s_r, ovf_s_nxt;
  logic                res_vld_r, res_vld_nxt;
  logic [CadW-1:0]     res_cad_r, res_cad_nxt;
  logic [SpdW-1:0]     res_spd_r, res_spd_nxt;
  logic                res_flag_r, res_flag_nxt;

  // Combinational helpers
  logic                in_beat;
  logic                cfg_wr;
  logic [TimeW-1:0]    dct_in, dst_in;
  logic [CountW-1:0]   dcn_in, dsn_in;
  logic                page_ok;
  logic [NineW-1:0]    ninep;
  logic [CadW:0]       t_c, d_c;
  logic [CadW:0]       t_s, d_s;
  logic                ge_c, ge_s;

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat = in_valid && in_ready;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegCirc);
  assign prdata = (paddr[2] == RegCirc) ? {{(DataW-CircW){1'b0}}, circ_r} : '0;

  assign out_valid = out_valid_r;
  assign out_rates_valid = res_vld_r;
  assign out_crank_rpm = res_cad_r;
  assign out_speed_tenths = res_spd_r;
  assign out_overflow_or_zero_time = res_flag_r;

  // Wrapping differences against the stored page
  assign dct_in = in_cadence_event_time - prev_ct_r;
  assign dcn_in = in_cadence_revolutions - prev_cn_r;
  assign dst_in = in_speed_event_time - prev_st_r;
  assign dsn_in = in_speed_revolutions - prev_sn_r;
  assign page_ok = (dcn_in != '0) && (dsn_in != '0);

  // Speed numerator is 36864 * product = (9 * product) << 12
  assign ninep = {1'b0, acc_r, 3'b000} + {4'b0000, acc_r};

  // Restoring divider steps, one quotient bit each
  assign t_c = {rem_c_r, qn_c_r[CadW-1]};
  assign d_c = t_c - {1'b0, dct_r};
  assign ge_c = (t_c >= {1'b0, dct_r});
  assign t_s = {rem_s_r[TimeW-1:0], qn_s_r[SpdW-1]};
  assign d_s = t_s - {1'b0, dst_r};
  assign ge_s = (t_s >= {1'b0, dst_r});

  // Sequencer and datapath next values
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r;
    circ_nxt = circ_r;
    prev_ct_nxt = prev_ct_r;
    prev_cn_nxt = prev_cn_r;
    prev_st_nxt = prev_st_r;
    prev_sn_nxt = prev_sn_r;
    vld_nxt = vld_r;
    dct_nxt = dct_r;
    dst_nxt = dst_r;
    dsn_nxt = dsn_r;
    ncad_nxt = ncad_r;
    mc_nxt = mc_r;
    acc_nxt = acc_r;
    rem_c_nxt = rem_c_r;
    qn_c_nxt = qn_c_r;
    rem_s_nxt = rem_s_r;
    qn_s_nxt = qn_s_r;
    ovf_c_nxt = ovf_c_r;
    ovf_s_nxt = ovf_s_r;
    res_vld_nxt = res_vld_r;
    res_cad_nxt = res_cad_r;
    res_spd_nxt = res_spd_r;
    res_flag_nxt = res_flag_r;

    // Drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      circ_nxt = pwdata[CircW-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          vld_nxt = page_ok;
          dct_nxt = dct_in;
          dst_nxt = dst_in;
          dsn_nxt = dsn_in;
          // 61440 * n = (n << 16) - (n << 12)
          ncad_nxt = {dcn_in, 16'h0000} - {4'h0, dcn_in, 12'h000};
          mc_nxt = circ_r;
          acc_nxt = '0;
          cnt_nxt = '0;
          if (page_ok) begin
            prev_ct_nxt = in_cadence_event_time;
            prev_cn_nxt = in_cadence_revolutions;
            prev_st_nxt = in_speed_event_time;
            prev_sn_nxt = in_speed_revolutions;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_MUL: begin
        // Shift-add, circumference MSB first
        acc_nxt = {acc_r[ProdW-2:0], 1'b0} +
                  (mc_r[CircW-1] ? {{CircW{1'b0}}, dsn_r} : '0);
        mc_nxt = {mc_r[CircW-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == StepW'(CircW - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // Load remainders with the numerator tops, quotient regs with the rest
        rem_c_nxt = ncad_r[CadNumW-1:CadW];
        qn_c_nxt = ncad_r[CadW-1:0];
        rem_s_nxt = ninep[NineW-1:12];
        qn_s_nxt = {ninep[11:0], 12'h000};
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Quotient would not fit when the numerator top already reaches the divisor
        if (cnt_r == '0) begin
          ovf_c_nxt = (rem_c_r >= dct_r);
          ovf_s_nxt = (rem_s_r >= {{(SpdRemW-TimeW){1'b0}}, dst_r});
        end
        if (cnt_r < StepW'(CadW)) begin
          rem_c_nxt = ge_c ? d_c[CadW-1:0] : t_c[CadW-1:0];
          qn_c_nxt = {qn_c_r[CadW-2:0], ge_c};
        end
        rem_s_nxt = {{(SpdRemW-TimeW){1'b0}}, (ge_s ? d_s[TimeW-1:0] : t_s[TimeW-1:0])};
        qn_s_nxt = {qn_s_r[SpdW-2:0], ge_s};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == StepW'(SpdW - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          res_vld_nxt = vld_r;
          res_cad_nxt = !vld_r ? '0 : (ovf_c_r ? CadMax : qn_c_r);
          res_spd_nxt = !vld_r ? '0 : (ovf_s_r ? SpdMax : qn_s_r);
          res_flag_nxt = vld_r && (ovf_c_r || ovf_s_r);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      circ_r <= CircReset;
      prev_ct_r <= PrevTimeReset;
      prev_cn_r <= PrevCountReset;
      prev_st_r <= PrevTimeReset;
      prev_sn_r <= PrevCountReset;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      circ_r <= circ_nxt;
      prev_ct_r <= prev_ct_nxt;
      prev_cn_r <= prev_cn_nxt;
      prev_st_r <= prev_st_nxt;
      prev_sn_r <= prev_sn_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    vld_r <= vld_nxt;
    dct_r <= dct_nxt;
    dst_r <= dst_nxt;
    dsn_r <= dsn_nxt;
    ncad_r <= ncad_nxt;
    mc_r <= mc_nxt;
    acc_r <= acc_nxt;
    rem_c_r <= rem_c_nxt;
    qn_c_r <= qn_c_nxt;
    rem_s_r <= rem_s_nxt;
    qn_s_r <= qn_s_nxt;
    ovf_c_r <= ovf_c_nxt;
    ovf_s_r <= ovf_s_nxt;
    res_vld_r <= res_vld_nxt;
    res_cad_r <= res_cad_nxt;
    res_spd_r <= res_spd_nxt;
    res_flag_r <= res_flag_nxt;
  end

  // Checks
  `ASSERT_PROP(a_page_held, clk, rst_n, !in_beat |=> $stable(prev_cn_r) && $stable(prev_sn_r), "stored page moved without an input beat")
  `ASSERT_PROP(a_idle_result_zero, clk, rst_n, out_valid_r && !res_vld_r |-> res_cad_r == '0 && res_spd_r == '0 && !res_flag_r, "unmoved page gave nonzero result")
  `ASSERT_PROP(a_div_count, clk, rst_n, state_r == ST_DIV |-> cnt_r < StepW'(SpdW), "divider ran past its last step")
  `ASSERT_PROP(a_zero_time_sat, clk, rst_n, state_r == ST_HOLD && vld_r && dst_r == '0 |-> ovf_s_r, "zero wheel time did not saturate")
  `ASSERT_PROP(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready |=> out_valid_r && $stable(res_spd_r), "waiting result was overwritten")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import scpr_pkg::*;

  // Register map: index 0 holds the circumference, index 1 is unmapped
  localparam logic [AddrW-1:0] CIRC_ADDR = AddrW'(4 * RegCirc);
  localparam logic [AddrW-1:0] SPARE_ADDR = AddrW'(4);
  localparam int NDIR = 22;
  localparam int NPHASE = 6;
  localparam int PHASE_PAGES = 315;
  localparam int PAUSE_AT = 150;
  localparam int CALM_FROM = 165;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [TimeW-1:0]  crank_time;
    logic [CountW-1:0] crank_revs;
    logic [TimeW-1:0]  wheel_time;
    logic [CountW-1:0] wheel_revs;
  } page_t;

  typedef struct packed {
    logic            rates_valid;
    logic [CadW-1:0] crank_rpm;
    logic [SpdW-1:0] speed_tenths;
    logic            flag;
  } rate_t;

  typedef struct packed {
    logic             is_write;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    page_t            page;
    logic             typed;
    rate_t            want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TimeW-1:0] in_cadence_event_time = '0;
  logic [CountW-1:0] in_cadence_revolutions = '0;
  logic [TimeW-1:0] in_speed_event_time = '0;
  logic [CountW-1:0] in_speed_revolutions = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_rates_valid;
  logic [CadW-1:0] out_crank_rpm;
  logic [SpdW-1:0] out_speed_tenths;
  logic out_overflow_or_zero_time;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  // Mirror of the block: circumference and the last accepted page
  logic [CircW-1:0] circ_mm = CircReset;
  logic [TimeW-1:0] last_crank_time = PrevTimeReset;
  logic [CountW-1:0] last_crank_revs = PrevCountReset;
  logic [TimeW-1:0] last_wheel_time = PrevTimeReset;
  logic [CountW-1:0] last_wheel_revs = PrevCountReset;

  rate_t expected_rates[$];
  rate_t seen_want, seen_got;
  row_t directed[NDIR];

  int errors = 0;
  int pages_sent = 0;
  int valid_pages = 0;
  int flagged_pages = 0;
  int reg_writes = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  speed_cadence_page_rate u_top (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_cadence_event_time     (in_cadence_event_time),
    .in_cadence_revolutions    (in_cadence_revolutions),
    .in_speed_event_time       (in_speed_event_time),
    .in_speed_revolutions      (in_speed_revolutions),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_rates_valid           (out_rates_valid),
    .out_crank_rpm             (out_crank_rpm),
    .out_speed_tenths          (out_speed_tenths),
    .out_overflow_or_zero_time (out_overflow_or_zero_time),
    .psel                      (psel),
    .penable                   (penable),
    .pwrite                    (pwrite),
    .paddr                     (paddr),
    .pwdata                    (pwdata),
    .prdata                    (prdata),
    .pready                    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the rates of one page and advance the stored page when both counts moved
  function automatic rate_t page_rates(input page_t p);
    logic [TimeW-1:0] d_ct, d_st;
    logic [CountW-1:0] d_cn, d_sn;
    logic [63:0] q;
    rate_t r;
    d_ct = p.crank_time - last_crank_time;
    d_cn = p.crank_revs - last_crank_revs;
    d_st = p.wheel_time - last_wheel_time;
    d_sn = p.wheel_revs - last_wheel_revs;
    r = '0;
    if (d_cn != 0 && d_sn != 0) begin
      r.rates_valid = 1'b1;
      // Crank rate: 60 * 1024 revolutions per tick difference
      if (d_ct == 0) begin
        r.crank_rpm = CadMax;
        r.flag = 1'b1;
      end else begin
        q = (64'd61440 * 64'(d_cn)) / 64'(d_ct);
        if (q > 64'(CadMax)) begin
          r.crank_rpm = CadMax;
          r.flag = 1'b1;
        end else begin
          r.crank_rpm = q[CadW-1:0];
        end
      end
      // Wheel rate: 3.6 * 1024 * circumference in tenths
      if (d_st == 0) begin
        r.speed_tenths = SpdMax;
        r.flag = 1'b1;
      end else begin
        q = (64'd36864 * 64'(circ_mm) * 64'(d_sn)) / 64'(d_st);
        if (q > 64'(SpdMax)) begin
          r.speed_tenths = SpdMax;
          r.flag = 1'b1;
        end else begin
          r.speed_tenths = q[SpdW-1:0];
        end
      end
      last_crank_time = p.crank_time;
      last_crank_revs = p.crank_revs;
      last_wheel_time = p.wheel_time;
      last_wheel_revs = p.wheel_revs;
    end
    return r;
  endfunction

  function automatic row_t page_row(input logic [15:0] ct, cn, st, sn);
    row_t r;
    r = '0;
    r.page = '{ct, cn, st, sn};
    return r;
  endfunction

  function automatic row_t checked_row(input logic [15:0] ct, cn, st, sn,
                                       input logic v, input logic [CadW-1:0] c,
                                       input logic [SpdW-1:0] s, input logic f);
    row_t r;
    r = page_row(ct, cn, st, sn);
    r.typed = 1'b1;
    r.want = '{v, c, s, f};
    return r;
  endfunction

  function automatic row_t write_row(input logic [AddrW-1:0] a, input logic [DataW-1:0] d);
    row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.addr = a;
    r.data = d;
    return r;
  endfunction

  // Present one page, hold it until taken, then queue its rates
  task automatic send_page(input page_t p, input logic typed, input rate_t want);
    rate_t r;
    in_valid <= 1'b1;
    in_cadence_event_time <= p.crank_time;
    in_cadence_revolutions <= p.crank_revs;
    in_speed_event_time <= p.wheel_time;
    in_speed_revolutions <= p.wheel_revs;
    do @(posedge clk); while (!in_ready);
    r = page_rates(p);
    if (typed) r = want;
    expected_rates.push_back(r);
    pages_sent++;
    if (r.rates_valid) valid_pages++;
    if (r.flag) flagged_pages++;
  endtask

  // Drain the block, then run one register write through setup and access
  task automatic write_register(input logic [AddrW-1:0] a, input logic [DataW-1:0] d);
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == CIRC_ADDR) circ_mm = d[CircW-1:0];
    reg_writes++;
  endtask

  // Receiver: stall in random bursts, none once the run calms down
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest queued rates
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_got = '{out_rates_valid, out_crank_rpm, out_speed_tenths,
                   out_overflow_or_zero_time};
      if (expected_rates.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, got %h", $time, seen_got);
      end else begin
        seen_want = expected_rates.pop_front();
        if (seen_got !== seen_want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            if (seen_got.rates_valid !== seen_want.rates_valid)
              $display("%0t: rates_valid expected %0d got %0d", $time,
                       seen_want.rates_valid, seen_got.rates_valid);
            if (seen_got.crank_rpm !== seen_want.crank_rpm)
              $display("%0t: crank_rpm expected %0d got %0d", $time,
                       seen_want.crank_rpm, seen_got.crank_rpm);
            if (seen_got.speed_tenths !== seen_want.speed_tenths)
              $display("%0t: speed_tenths expected %0d got %0d", $time,
                       seen_want.speed_tenths, seen_got.speed_tenths);
            if (seen_got.flag !== seen_want.flag)
              $display("%0t: overflow_or_zero_time expected %0d got %0d", $time,
                       seen_want.flag, seen_got.flag);
          end
        end
      end
    end
  end

  // Stimulus: directed table, then random phases at several circumferences
  initial begin
    page_t p;
    int sel;
    logic [TimeW-1:0] dt;
    logic [CountW-1:0] dn;
    logic [DataW-1:0] d;

    directed = '{
      // revolutions unchanged after reset
      checked_row(16'd0, 16'd1, 16'd0, 16'd1, 1'b0, '0, '0, 1'b0),
      // both time differences zero
      checked_row(16'd0, 16'd2, 16'd0, 16'd2, 1'b1, CadMax, SpdMax, 1'b1),
      // wheel count still, then crank count still
      checked_row(16'd1024, 16'd3, 16'd1024, 16'd2, 1'b0, '0, '0, 1'b0),
      checked_row(16'd1024, 16'd2, 16'd1024, 16'd3, 1'b0, '0, '0, 1'b0),
      // one second, one revolution each, reset circumference
      checked_row(16'd1024, 16'd3, 16'd1024, 16'd3, 1'b1, 16'd60, 24'd72000, 1'b0),
      // event time wrap, counter wrap, all ones, longest interval
      page_row(16'd0, 16'd4, 16'd0, 16'd4),
      page_row(16'd1, 16'd3, 16'd1, 16'd3),
      page_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      page_row(16'hFFFE, 16'h0000, 16'hFFFE, 16'h0000),
      // zero circumference
      write_row(CIRC_ADDR, 32'h0000_0000),
      checked_row(16'h03FE, 16'd1, 16'h03FE, 16'd1, 1'b1, 16'd60, 24'd0, 1'b0),
      checked_row(16'h03FE, 16'd2, 16'h03FE, 16'd2, 1'b1, CadMax, SpdMax, 1'b1),
      // largest circumference, upper data bits set
      write_row(CIRC_ADDR, 32'hFFFF_FFFF),
      checked_row(16'h07FE, 16'd3, 16'h07FE, 16'd3, 1'b1, 16'd60, 24'd147420, 1'b0),
      page_row(16'h0800, 16'd2, 16'h0800, 16'd2),
      // unmapped register must not change the circumference
      write_row(SPARE_ADDR, 32'h0000_0ABC),
      checked_row(16'h0C00, 16'd3, 16'h0C00, 16'd3, 1'b1, 16'd60, 24'd147420, 1'b0),
      write_row(CIRC_ADDR, 32'hA5A5_F7D0),
      page_row(16'h1234, 16'h0008, 16'h5678, 16'h0010),
      page_row(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA),
      page_row(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555),
      checked_row(16'h1111, 16'hAAAA, 16'h2222, 16'h5556, 1'b0, '0, '0, 1'b0)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_write)
        write_register(directed[i].addr, directed[i].data);
      else
        send_page(directed[i].page, directed[i].typed, directed[i].want);
    end

    for (int ph = 0; ph < NPHASE; ph++) begin
      // Pick the circumference of this phase and how busy each side is
      case (ph)
        0: d = $urandom;
        1: d = 32'h0000_0000;
        2: d = 32'h0000_0FFF;
        3: d = 32'h0000_0001;
        4: begin
          write_register(SPARE_ADDR, $urandom);
          d = $urandom;
        end
        default: d = 32'h0000_07D0;
      endcase
      write_register(CIRC_ADDR, d);
      case (ph)
        0: begin idle_pct = 20; stall_pct = 30; end
        1: begin idle_pct = 0;  stall_pct = 10; end
        2: begin idle_pct = 40; stall_pct = 0;  end
        3: begin idle_pct = 10; stall_pct = 40; end
        4: begin idle_pct = 30; stall_pct = 20; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase

      for (int k = 0; k < PHASE_PAGES; k++) begin
        calm = (ph == NPHASE - 1) && (k >= CALM_FROM);
        sel = $urandom_range(0, 99);
        p.crank_time = TimeW'($urandom);
        p.crank_revs = CountW'($urandom);
        p.wheel_time = TimeW'($urandom);
        p.wheel_revs = CountW'($urandom);
        if (sel < 60) begin
          // Plausible riding: small count steps over realistic intervals
          dn = CountW'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(1, 8));
          dt = TimeW'($urandom_range(1, 6000));
          p.crank_revs = last_crank_revs + dn;
          p.crank_time = last_crank_time + dt;
          dn = CountW'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                   : $urandom_range(1, 8));
          dt = TimeW'($urandom_range(1, 6000));
          p.wheel_revs = last_wheel_revs + dn;
          p.wheel_time = last_wheel_time + dt;
        end else if (sel < 70) begin
          // Hold one revolution count
          if ($urandom_range(0, 1)) p.crank_revs = last_crank_revs;
          else p.wheel_revs = last_wheel_revs;
        end else if (sel < 78) begin
          // Repeat one or both event times with moving counts
          p.crank_revs = last_crank_revs + CountW'($urandom_range(1, 8));
          p.wheel_revs = last_wheel_revs + CountW'($urandom_range(1, 8));
          if ($urandom_range(0, 2) != 0) p.crank_time = last_crank_time;
          if ($urandom_range(0, 2) != 1) p.wheel_time = last_wheel_time;
        end else if (sel < 85) begin
          // Push both rates toward saturation
          p.crank_revs = last_crank_revs + CountW'($urandom_range(2000, 65535));
          p.crank_time = last_crank_time + TimeW'($urandom_range(1, 3));
          p.wheel_revs = last_wheel_revs + CountW'($urandom_range(1, 65535));
          p.wheel_time = last_wheel_time + TimeW'($urandom_range(1, 3));
        end
        send_page(p, 1'b0, '0);

        if (k == PAUSE_AT) begin
          // Hold off until every queued result is out
          in_valid <= 1'b0;
          while (expected_rates.size() != 0) @(posedge clk);
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_rates.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d pages: %0d with valid rates, %0d flagged for zero time or saturation",
             pages_sent, valid_pages, flagged_pages);
    $display("Circumference written %0d times, including 0, 4095 and an unmapped address",
             reg_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/scpr_pkg.sv
design/speed_cadence_page_rate.sv
tb/testbench.sv
